/* rtl/indexed_linked_multi_queue_unit_assert.svh */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LINKED_MULTI_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_LINKED_MULTI_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define ILMQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ilmq_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit: package
// Sizes, request codes, micro-operation codes and the shared types.
// ----------------------------------------------------------------------------
package ilmq_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int NUM_QUEUES  = NUM_ENTRIES + 1;
  localparam int ID_W        = $clog2(NUM_ENTRIES + 1);
  localparam int EA_W        = $clog2(NUM_ENTRIES);
  localparam int QA_W        = $clog2(NUM_QUEUES);
  localparam int TYPE_W      = 2;

  localparam logic [ID_W-1:0] NIL_ID = ID_W'(NUM_ENTRIES);

  localparam logic [TYPE_W-1:0] REQ_ENQ = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_DEQ = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_REM = 2'd2;

  localparam int UOP_W = 4;
  localparam logic [UOP_W-1:0] UOP_IDLE       = 4'd0;
  localparam logic [UOP_W-1:0] UOP_ACCEPT     = 4'd1;
  localparam logic [UOP_W-1:0] UOP_LOAD       = 4'd2;
  localparam logic [UOP_W-1:0] UOP_ENQ_LINK   = 4'd3;
  localparam logic [UOP_W-1:0] UOP_ENQ_TERM   = 4'd4;
  localparam logic [UOP_W-1:0] UOP_DEQ_UNLINK = 4'd5;
  localparam logic [UOP_W-1:0] UOP_DEQ_HEAD   = 4'd6;
  localparam logic [UOP_W-1:0] UOP_REM_LINK   = 4'd7;
  localparam logic [UOP_W-1:0] UOP_REM_CLEAR  = 4'd8;
  localparam logic [UOP_W-1:0] UOP_RESULT     = 4'd9;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   queue_id;
    logic [EA_W-1:0]   item_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] popped_id;
    logic            got_item;
  } rsp_t;

  typedef struct packed {
    logic [UOP_W-1:0] uop;
  } cmd_t;

  typedef struct packed {
    logic              req_ok;
    logic [TYPE_W-1:0] req_type;
    logic              head_entry;
    logic              rsp_full;
  } sts_t;

  function automatic logic is_entry(logic [ID_W-1:0] id);
    return id < ID_W'(NUM_ENTRIES);
  endfunction

endpackage

/* rtl/ilmq_datapath.sv */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit: datapath
// Head, tail and link memories with valid bits, pointer registers and the
// result register.
// ----------------------------------------------------------------------------
module ilmq_datapath (
  input  logic           clk,
  input  logic           rst,
  input  ilmq_pkg::req_t req,
  input  ilmq_pkg::cmd_t cmd,
  output ilmq_pkg::sts_t sts,
  input  logic           rsp_stall,
  output logic           rsp_valid,
  output ilmq_pkg::rsp_t rsp
);
  import ilmq_pkg::*;

  req_t            cur;
  logic [ID_W-1:0] h;
  logic [ID_W-1:0] t;
  logic [ID_W-1:0] p;
  logic [ID_W-1:0] n;

  logic [ID_W-1:0] head_mem [0:NUM_QUEUES-1];
  logic [ID_W-1:0] tail_mem [0:NUM_QUEUES-1];
  logic [ID_W-1:0] prev_mem [0:NUM_ENTRIES-1];
  logic [ID_W-1:0] next_mem [0:NUM_ENTRIES-1];

  logic [NUM_QUEUES-1:0]  head_vld;
  logic [NUM_QUEUES-1:0]  tail_vld;
  logic [NUM_ENTRIES-1:0] prev_vld;
  logic [NUM_ENTRIES-1:0] next_vld;

  logic [ID_W-1:0] head_rdata;
  logic [ID_W-1:0] tail_rdata;
  logic [ID_W-1:0] prev_rdata;
  logic [ID_W-1:0] next_rdata;
  logic            head_rvld;
  logic            tail_rvld;
  logic            prev_rvld;
  logic            next_rvld;
  logic [ID_W-1:0] head_rd;
  logic [ID_W-1:0] tail_rd;
  logic [ID_W-1:0] prev_rd;
  logic [ID_W-1:0] next_rd;
  logic [EA_W-1:0] next_raddr;
  logic            q_in_ok;

  logic            head_we;
  logic            tail_we;
  logic            prev_we;
  logic            next_we;
  logic [QA_W-1:0] head_waddr;
  logic [QA_W-1:0] tail_waddr;
  logic [EA_W-1:0] prev_waddr;
  logic [EA_W-1:0] next_waddr;
  logic [ID_W-1:0] head_wdata;
  logic [ID_W-1:0] tail_wdata;
  logic [ID_W-1:0] prev_wdata;
  logic [ID_W-1:0] next_wdata;

  logic [ID_W-1:0] e_id;
  logic            req_ok;
  logic            pop_hit;

  assign e_id    = ID_W'(cur.item_id);
  assign req_ok  = (cur.queue_id < ID_W'(NUM_QUEUES)) &&
                   ((cur.req_type == REQ_DEQ) || is_entry(e_id));
  assign pop_hit = (cur.req_type == REQ_DEQ) && req_ok && is_entry(h);
  assign q_in_ok = req.queue_id < ID_W'(NUM_QUEUES);

  assign head_rd = head_rvld ? head_rdata : NIL_ID;
  assign tail_rd = tail_rvld ? tail_rdata : NIL_ID;
  assign prev_rd = prev_rvld ? prev_rdata : NIL_ID;
  assign next_rd = next_rvld ? next_rdata : NIL_ID;

  assign next_raddr = (cmd.uop == UOP_LOAD) ? head_rd[EA_W-1:0] : req.item_id;

  always_ff @(posedge clk) begin
    head_rdata <= head_mem[req.queue_id[QA_W-1:0]];
    tail_rdata <= tail_mem[req.queue_id[QA_W-1:0]];
    prev_rdata <= prev_mem[req.item_id];
    next_rdata <= next_mem[next_raddr];
    head_rvld  <= q_in_ok && head_vld[req.queue_id[QA_W-1:0]];
    tail_rvld  <= q_in_ok && tail_vld[req.queue_id[QA_W-1:0]];
    prev_rvld  <= prev_vld[req.item_id];
    next_rvld  <= next_vld[next_raddr];
  end

  always_comb begin
    head_we    = 1'b0;
    tail_we    = 1'b0;
    prev_we    = 1'b0;
    next_we    = 1'b0;
    head_waddr = cur.queue_id[QA_W-1:0];
    tail_waddr = cur.queue_id[QA_W-1:0];
    prev_waddr = cur.item_id;
    next_waddr = cur.item_id;
    head_wdata = NIL_ID;
    tail_wdata = NIL_ID;
    prev_wdata = NIL_ID;
    next_wdata = NIL_ID;
    case (cmd.uop)
      UOP_ENQ_LINK: begin
        head_we    = (t == NIL_ID);
        head_wdata = e_id;
        tail_we    = 1'b1;
        tail_wdata = e_id;
        prev_we    = 1'b1;
        prev_wdata = t;
        next_we    = 1'b1;
        if (is_entry(t)) begin
          next_waddr = t[EA_W-1:0];
          next_wdata = e_id;
        end
      end
      UOP_ENQ_TERM: begin
        next_we = 1'b1;
      end
      UOP_DEQ_UNLINK: begin
        prev_we    = 1'b1;
        prev_waddr = h[EA_W-1:0];
        next_we    = 1'b1;
        next_waddr = h[EA_W-1:0];
      end
      UOP_DEQ_HEAD: begin
        head_we    = 1'b1;
        head_wdata = n;
        tail_we    = (n == NIL_ID);
        prev_we    = is_entry(n);
        prev_waddr = n[EA_W-1:0];
      end
      UOP_REM_LINK: begin
        head_we    = (h == e_id);
        head_wdata = n;
        tail_we    = (t == e_id);
        tail_wdata = p;
        prev_we    = is_entry(n);
        prev_waddr = n[EA_W-1:0];
        prev_wdata = p;
        next_we    = is_entry(p);
        next_waddr = p[EA_W-1:0];
        next_wdata = n;
      end
      UOP_REM_CLEAR: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (tail_we) begin
      tail_mem[tail_waddr] <= tail_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_vld <= '0;
      tail_vld <= '0;
      prev_vld <= '0;
      next_vld <= '0;
    end else begin
      if (head_we) begin
        head_vld[head_waddr] <= 1'b1;
      end
      if (tail_we) begin
        tail_vld[tail_waddr] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld[prev_waddr] <= 1'b1;
      end
      if (next_we) begin
        next_vld[next_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.uop)
      UOP_ACCEPT: begin
        cur <= req;
      end
      UOP_LOAD: begin
        h <= head_rd;
        t <= tail_rd;
        p <= prev_rd;
        n <= next_rd;
      end
      UOP_DEQ_UNLINK: begin
        n <= next_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.uop == UOP_RESULT) begin
      rsp.popped_id <= pop_hit ? h : NIL_ID;
      rsp.got_item  <= pop_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.uop == UOP_RESULT) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign sts.req_ok     = req_ok;
  assign sts.req_type   = cur.req_type;
  assign sts.head_entry = is_entry(head_rd);
  assign sts.rsp_full   = rsp_valid && rsp_stall;

endmodule

/* rtl/ilmq_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit: controller
// Sequences each request through read, link update and result steps.
// ----------------------------------------------------------------------------
module ilmq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ilmq_pkg::sts_t sts,
  output ilmq_pkg::cmd_t cmd
);
  import ilmq_pkg::*;

  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE       = 4'd0;
  localparam logic [STATE_W-1:0] S_LOAD       = 4'd1;
  localparam logic [STATE_W-1:0] S_ENQ_LINK   = 4'd2;
  localparam logic [STATE_W-1:0] S_ENQ_TERM   = 4'd3;
  localparam logic [STATE_W-1:0] S_DEQ_UNLINK = 4'd4;
  localparam logic [STATE_W-1:0] S_DEQ_HEAD   = 4'd5;
  localparam logic [STATE_W-1:0] S_REM_LINK   = 4'd6;
  localparam logic [STATE_W-1:0] S_REM_CLEAR  = 4'd7;
  localparam logic [STATE_W-1:0] S_RESULT     = 4'd8;

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.uop    = UOP_IDLE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.uop    = UOP_ACCEPT;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.uop = UOP_LOAD;
        if (!sts.req_ok) begin
          state_next = S_RESULT;
        end else begin
          case (sts.req_type)
            REQ_ENQ: state_next = S_ENQ_LINK;
            REQ_DEQ: state_next = sts.head_entry ? S_DEQ_UNLINK : S_RESULT;
            REQ_REM: state_next = S_REM_LINK;
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_ENQ_LINK: begin
        cmd.uop    = UOP_ENQ_LINK;
        state_next = S_ENQ_TERM;
      end
      S_ENQ_TERM: begin
        cmd.uop    = UOP_ENQ_TERM;
        state_next = S_RESULT;
      end
      S_DEQ_UNLINK: begin
        cmd.uop    = UOP_DEQ_UNLINK;
        state_next = S_DEQ_HEAD;
      end
      S_DEQ_HEAD: begin
        cmd.uop    = UOP_DEQ_HEAD;
        state_next = S_RESULT;
      end
      S_REM_LINK: begin
        cmd.uop    = UOP_REM_LINK;
        state_next = S_REM_CLEAR;
      end
      S_REM_CLEAR: begin
        cmd.uop    = UOP_REM_CLEAR;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.rsp_full) begin
          cmd.uop    = UOP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/indexed_linked_multi_queue_unit.sv */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit
// Doubly linked queues over a shared entry pool: enqueue, dequeue, remove.
// ----------------------------------------------------------------------------
// One request is taken at a time. Enqueue, remove and a dequeue that finds an
// entry pass through the load, link update and result steps before the next
// transfer; a dequeue from an empty queue and an ignored request go from load
// straight to result. The steps follow from the single write port of each head,
// tail and link memory and its registered reads: the links are read in the load
// step and rewritten in the update steps. The result sits in its own register,
// so a request can be taken while the previous result still waits. Memories
// reset through per-entry valid bits, so the block is ready as soon as reset ends.
`include "indexed_linked_multi_queue_unit_assert.svh"

module indexed_linked_multi_queue_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ilmq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ilmq_pkg::rsp_t rsp
);
  import ilmq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ilmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ilmq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  `ILMQ_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall, "input open after transfer")
  `ILMQ_ASSERT_NEXT(a_accept_load, req_valid && !req_stall, cmd.uop == UOP_LOAD, "no link read")
  `ILMQ_ASSERT_NOW(a_deq_real, cmd.uop == UOP_DEQ_UNLINK, $past(sts.head_entry), "pop of null head")
  `ILMQ_ASSERT_NEXT(a_result_held, cmd.uop == UOP_RESULT, rsp_valid, "result not presented")
  `ILMQ_ASSERT_NOW(a_got_flag, rsp_valid, rsp.got_item == (rsp.popped_id != NIL_ID), "flag mismatch")

endmodule

/* dv/indexed_linked_multi_queue_unit_checker.sv */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit: transfer checker
// Watches both channels, keeps its own copy of the heads, tails and links,
// works out the result of each accepted request and compares it, field by
// field, with the oldest outstanding result.
// ----------------------------------------------------------------------------
module indexed_linked_multi_queue_unit_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  ilmq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  ilmq_pkg::rsp_t rsp,
  output int             failures,
  output int             pending
);
  import ilmq_pkg::*;

  logic [ID_W-1:0] q_head [NUM_QUEUES];
  logic [ID_W-1:0] q_tail [NUM_QUEUES];
  logic [ID_W-1:0] e_prev [NUM_ENTRIES];
  logic [ID_W-1:0] e_next [NUM_ENTRIES];

  rsp_t outstanding[$];
  rsp_t oldest;
  int   mismatches;

  assign failures = mismatches;

  function automatic logic linked(logic [ID_W-1:0] id);
    return id < NIL_ID;
  endfunction

  function automatic void put_prev(logic [ID_W-1:0] id, logic [ID_W-1:0] v);
    if (linked(id)) e_prev[id[EA_W-1:0]] = v;
  endfunction

  function automatic void put_next(logic [ID_W-1:0] id, logic [ID_W-1:0] v);
    if (linked(id)) e_next[id[EA_W-1:0]] = v;
  endfunction

  function automatic rsp_t queue_op_result(req_t r);
    logic [ID_W-1:0] q;
    logic [ID_W-1:0] e;
    logic [ID_W-1:0] h;
    logic [ID_W-1:0] t;
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] n;
    rsp_t            res;
    q = r.queue_id;
    e = ID_W'(r.item_id);
    res.popped_id = NIL_ID;
    res.got_item  = 1'b0;
    if (q <= NIL_ID) begin
      case (r.req_type)
        REQ_ENQ: begin
          t = q_tail[q];
          if (t == NIL_ID) begin
            put_prev(e, NIL_ID);
            put_next(e, NIL_ID);
            q_head[q] = e;
          end else begin
            put_next(t, e);
            put_prev(e, t);
            put_next(e, NIL_ID);
          end
          q_tail[q] = e;
        end
        REQ_DEQ: begin
          h = q_head[q];
          if (linked(h)) begin
            n = e_next[h[EA_W-1:0]];
            if (n != NIL_ID) put_prev(n, NIL_ID);
            else q_tail[q] = NIL_ID;
            put_next(h, NIL_ID);
            put_prev(h, NIL_ID);
            q_head[q]     = n;
            res.popped_id = h;
            res.got_item  = 1'b1;
          end
        end
        REQ_REM: begin
          h = q_head[q];
          t = q_tail[q];
          p = e_prev[e[EA_W-1:0]];
          n = e_next[e[EA_W-1:0]];
          if (h == e) q_head[q] = n;
          if (t == e) q_tail[q] = p;
          if (n != NIL_ID) put_prev(n, p);
          if (p != NIL_ID) put_next(p, n);
          put_next(e, NIL_ID);
          put_prev(e, NIL_ID);
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  initial mismatches = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        q_head[i] = NIL_ID;
        q_tail[i] = NIL_ID;
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        e_prev[i] = NIL_ID;
        e_next[i] = NIL_ID;
      end
      outstanding.delete();
    end else begin
      if (req_valid === 1'b1 && req_stall === 1'b0) begin
        outstanding.push_back(queue_op_result(req));
      end
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (outstanding.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: popped_id %0d got_item %0b",
                     rsp.popped_id, rsp.got_item);
          end
          mismatches++;
        end else begin
          oldest = outstanding.pop_front();
          if (rsp.popped_id !== oldest.popped_id || rsp.got_item !== oldest.got_item) begin
            if (mismatches < 10) begin
              $display("result mismatch: expected popped_id %0d got_item %0b, actual %0d %0b",
                       oldest.popped_id, oldest.got_item, rsp.popped_id, rsp.got_item);
            end
            mismatches++;
          end
        end
      end
    end
    pending <= outstanding.size();
  end

endmodule

/* dv/indexed_linked_multi_queue_unit_test.sv */
// ----------------------------------------------------------------------------
// Indexed linked multi-queue unit: testbench top
// Drives a directed run over the list corner cases, then random requests
// that mostly keep the queues well formed, with random idling on both sides
// and long receiver hold-offs; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module indexed_linked_multi_queue_unit_test;
  import ilmq_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1265;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 120;
  localparam int TOP_QUEUE_ID = (1 << ID_W) - 1;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   failures;
  int   pending;
  int   cycles;

  req_t plan[$];
  int   owner [NUM_ENTRIES];
  int   stamp [NUM_ENTRIES];
  int   stamp_next;
  bit   calm;
  bit   hold_off;

  indexed_linked_multi_queue_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  indexed_linked_multi_queue_unit_checker queue_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("indexed_linked_multi_queue_unit_test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // random entry whose owner is q; q of -1 picks a free entry
  function automatic int pick_member(int q);
    int hits[$];
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (owner[e] == q) hits.push_back(e);
    end
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(0, hits.size() - 1)];
  endfunction

  function automatic void plan_request(logic [TYPE_W-1:0] op, int q, int e);
    req_t r;
    int   oldest;
    r.req_type = op;
    r.queue_id = ID_W'(q);
    r.item_id  = EA_W'(e);
    plan.push_back(r);
    if (q < NUM_QUEUES) begin
      case (op)
        REQ_ENQ: begin
          owner[e] = q;
          stamp[e] = stamp_next++;
        end
        REQ_DEQ: begin
          oldest = -1;
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (owner[i] == q && (oldest < 0 || stamp[i] < stamp[oldest])) oldest = i;
          end
          if (oldest >= 0) owner[oldest] = -1;
        end
        REQ_REM: begin
          if (owner[e] == q) owner[e] = -1;
        end
        default: ;
      endcase
    end
  endfunction

  initial begin
    int busy [4];
    int counted;
    int roll;
    int choice;
    int q;
    int e_free;
    int e_in;
    int gap;
    for (int i = 0; i < NUM_ENTRIES; i++) owner[i] = -1;
    stamp_next = 0;
    calm       = 1'b0;
    hold_off   = 1'b0;

    plan_request(REQ_DEQ, 0, 0);
    plan_request(REQ_ENQ, 0, 0);
    plan_request(REQ_ENQ, 0, NUM_ENTRIES - 1);
    plan_request(REQ_ENQ, 0, 21);
    plan_request(REQ_ENQ, 0, 42);
    plan_request(REQ_REM, 0, 21);
    plan_request(REQ_REM, 0, 0);
    plan_request(REQ_REM, 0, 42);
    plan_request(REQ_DEQ, 0, 63);
    plan_request(REQ_DEQ, 0, 0);
    plan_request(REQ_ENQ, NUM_QUEUES - 1, 10);
    plan_request(REQ_ENQ, NUM_QUEUES - 1, 11);
    plan_request(REQ_DEQ, NUM_QUEUES - 1, 0);
    plan_request(REQ_DEQ, NUM_QUEUES - 1, 0);
    plan_request(REQ_DEQ, NUM_QUEUES - 1, 0);
    plan_request(REQ_ENQ, 5, 7);
    plan_request(REQ_REM, 5, 7);
    plan_request(REQ_REM, 3, 50);
    plan_request(REQ_UNUSED, 0, 1);
    plan_request(REQ_ENQ, TOP_QUEUE_ID, 1);
    plan_request(REQ_DEQ, NUM_QUEUES, 0);
    plan_request(REQ_REM, 100, 2);
    plan_request(REQ_DEQ, 5, 0);

    busy[0] = 0;
    busy[1] = NUM_QUEUES - 1;
    busy[2] = $urandom_range(1, NUM_QUEUES - 2);
    busy[3] = $urandom_range(1, NUM_QUEUES - 2);
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        plan_request(REQ_UNUSED, $urandom_range(0, TOP_QUEUE_ID),
                     $urandom_range(0, NUM_ENTRIES - 1));
      end else if (roll < 8) begin
        plan_request(TYPE_W'($urandom_range(0, 3)), $urandom_range(NUM_QUEUES, TOP_QUEUE_ID),
                     $urandom_range(0, NUM_ENTRIES - 1));
      end else begin
        counted++;
        q = $urandom_range(0, 1) ? busy[$urandom_range(0, 3)]
                                 : $urandom_range(0, NUM_QUEUES - 1);
        if (roll < 14 && counted > RANDOM_ITEMS - 200) begin
          plan_request($urandom_range(0, 1) ? REQ_ENQ : REQ_REM, q,
                       $urandom_range(0, NUM_ENTRIES - 1));
        end else begin
          e_free = pick_member(-1);
          e_in   = pick_member(q);
          choice = $urandom_range(0, 99);
          if (e_free >= 0 && choice < 48) plan_request(REQ_ENQ, q, e_free);
          else if (e_in >= 0 && choice < 74) plan_request(REQ_REM, q, e_in);
          else plan_request(REQ_DEQ, q, $urandom_range(0, NUM_ENTRIES - 1));
        end
      end
    end

    req_valid <= 1'b0;
    req       <= '0;
    @(posedge clk iff !rst);
    foreach (plan[i]) begin
      if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == 300 || i == 1000) hold_off = 1'b1;
      gap = pick_gap();
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_valid <= 1'b1;
      req       <= plan[i];
      do @(posedge clk); while (req_stall !== 1'b0);
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("indexed_linked_multi_queue_unit_test passed");
    end else begin
      $display("indexed_linked_multi_queue_unit_test failed");
    end
    $finish;
  end

  initial begin
    int gap;
    rsp_stall <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        gap      = HOLD_CYCLES;
        hold_off = 1'b0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

endmodule
